// ===== rtl/core/spc_pkg.sv =====
// Shared types and codes for the segment ping-pong capture block.
`timescale 1ns / 1ps

package spc_pkg;

  localparam int unsigned BUFFER_DEPTH_DEFAULT = 2048;

  typedef enum logic [2:0] {
    ACT_WORD      = 3'd0,
    ACT_FRAME_END = 3'd1,
    ACT_LOCK      = 3'd2,
    ACT_UNLOCK    = 3'd3,
    ACT_READ      = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NONE      = 3'd1,
    ST_DISABLED  = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_DROPPED   = 3'd4
  } status_t;

  localparam logic REG_CAPTURE_ENABLE = 1'b0;

endpackage

// ===== rtl/core/segment_ping_pong_capture_core.sv =====
// Segment ping-pong capture core: two capture buffers, lock/unlock, word read-back.
`timescale 1ns / 1ps

// Captures 32-bit segment words into one of two buffers and hands finished
// buffers out through a non-blocking lock. One input word is taken every clock
// cycle while item_stall is low; its result word passes an intermediate stage,
// which waits for the registered read port of the segment store, and an output
// register. Together they let two results wait while result_stall is high before
// item_stall rises. The store is 2*BUFFER_DEPTH words in one RAM with one
// write and one read port; it is not cleared, and only positions below a
// buffer's recorded count can be read. capture_enable is at byte address 0.
module segment_ping_pong_capture_core
  import spc_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  action,
  input  logic [31:0] segment_word,
  input  logic [1:0]  buffer_sel,
  input  logic [10:0] entry_addr,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic        buffer_index,
  output logic [11:0] segment_count,
  output logic [31:0] frame_tag,
  output logic [31:0] read_word,
  output logic        new_data
);

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);  // count width
  localparam int unsigned PW = $clog2(BUFFER_DEPTH);      // position in buffer
  localparam int unsigned MW = $clog2(2 * BUFFER_DEPTH);  // store address
  localparam int unsigned STORE_WORDS = 2 * BUFFER_DEPTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [MW-1:0] DEPTH_M = MW'(BUFFER_DEPTH);

  // architectural state
  logic          capture_enable;
  logic          grab_buffer;
  logic [CW-1:0] write_position;
  logic [1:0]    finished_flags;
  logic [1:0]    lock_flags;
  logic [CW-1:0] count_0, count_1;
  logic [31:0]   tag_0, tag_1;
  logic [31:0]   frame_counter;

  logic          grab_buffer_next;
  logic [CW-1:0] write_position_next;
  logic [1:0]    finished_flags_next;
  logic [1:0]    lock_flags_next;
  logic [CW-1:0] count_0_next, count_1_next;
  logic [31:0]   tag_0_next, tag_1_next;
  logic [31:0]   frame_counter_next;

  // segment store
  logic [31:0]   store [STORE_WORDS];
  logic [31:0]   store_rdata;
  logic          store_we, store_re;
  logic [MW-1:0] store_waddr, store_raddr;

  // middle stage
  logic          s1_valid;
  logic [2:0]    s1_status;
  logic          s1_index;
  logic [11:0]   s1_count;
  logic [31:0]   s1_tag;
  logic          s1_read;
  logic          s1_new;

  logic          item_accept, s1_adv, cfg_write;
  logic [2:0]    st_c;
  logic          idx_c;
  logic [CW-1:0] cnt_c;
  logic [31:0]   tag_c;
  logic          read_ok_c;

  logic [CW-1:0]    sel_count;
  logic [CW+10:0]   addr_wide, count_wide;
  logic [PW+10:0]   addr_pos_wide;
  logic [CW+11:0]   cnt_out_wide;
  logic             other;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && (paddr[2] == REG_CAPTURE_ENABLE);
  assign prdata      = (paddr[2] == REG_CAPTURE_ENABLE) ? {31'b0, capture_enable} : 32'b0;

  assign s1_adv      = s1_valid && (!result_valid || !result_stall);
  assign item_stall  = s1_valid && !s1_adv;
  assign item_accept = item_valid && !item_stall;

  assign sel_count     = buffer_sel[0] ? count_1 : count_0;
  assign addr_wide     = {{CW{1'b0}}, entry_addr};
  assign count_wide    = {11'b0, sel_count};
  assign addr_pos_wide = {{PW{1'b0}}, entry_addr};
  assign other         = !grab_buffer;

  always_comb begin
    grab_buffer_next    = grab_buffer;
    write_position_next = write_position;
    finished_flags_next = finished_flags;
    lock_flags_next     = lock_flags;
    count_0_next        = count_0;
    count_1_next        = count_1;
    tag_0_next          = tag_0;
    tag_1_next          = tag_1;
    frame_counter_next  = frame_counter;
    st_c      = ST_OK;
    idx_c     = 1'b0;
    cnt_c     = '0;
    tag_c     = '0;
    read_ok_c = 1'b0;
    store_we  = 1'b0;
    store_re  = 1'b0;
    store_waddr = grab_buffer ? (DEPTH_M + MW'(write_position[PW-1:0]))
                              : MW'(write_position[PW-1:0]);
    store_raddr = buffer_sel[0] ? (DEPTH_M + MW'(addr_pos_wide[PW-1:0]))
                                : MW'(addr_pos_wide[PW-1:0]);

    if (item_accept) begin
      case (action)
        ACT_WORD: begin
          if (!capture_enable) begin
            st_c = ST_DISABLED;
          end else if (write_position >= DEPTH_C) begin
            st_c = ST_DROPPED;
          end else begin
            store_we = 1'b1;
            write_position_next = write_position + CW'(1);
          end
        end
        ACT_FRAME_END: begin
          frame_counter_next = frame_counter + 32'd1;
          if (!capture_enable) begin
            st_c = ST_DISABLED;
          end else begin
            if (grab_buffer) begin
              count_1_next = write_position;
              tag_1_next   = frame_counter;
            end else begin
              count_0_next = write_position;
              tag_0_next   = frame_counter;
            end
            // switch to the other buffer unless it is locked
            grab_buffer_next = lock_flags[other] ? grab_buffer : other;
            finished_flags_next = finished_flags;
            finished_flags_next[grab_buffer] = 1'b1;
            finished_flags_next[grab_buffer_next] = 1'b0;
            write_position_next = '0;
          end
        end
        ACT_LOCK: begin
          if (!capture_enable) begin
            st_c = ST_DISABLED;
          end else if (finished_flags == 2'b00) begin
            st_c = ST_NONE;
          end else begin
            idx_c = !finished_flags[0];
            lock_flags_next[idx_c] = 1'b1;
            cnt_c = idx_c ? count_1 : count_0;
            tag_c = idx_c ? tag_1 : tag_0;
          end
        end
        ACT_UNLOCK: begin
          if (buffer_sel[1]) begin
            st_c = ST_BAD_INDEX;
          end else begin
            finished_flags_next[buffer_sel[0]] = 1'b0;
            lock_flags_next[buffer_sel[0]]     = 1'b0;
          end
        end
        ACT_READ: begin
          if (buffer_sel[1] || (addr_wide >= count_wide)) begin
            st_c = ST_BAD_INDEX;
          end else begin
            store_re  = 1'b1;
            read_ok_c = 1'b1;
          end
        end
        default: st_c = ST_BAD_INDEX;
      endcase
    end

    // re-arm clears the hand-off flags
    if (cfg_write && pwdata[0]) begin
      finished_flags_next = 2'b00;
      lock_flags_next     = 2'b00;
    end
  end

  assign cnt_out_wide = {12'b0, cnt_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
      grab_buffer    <= 1'b0;
      write_position <= '0;
      finished_flags <= 2'b00;
      lock_flags     <= 2'b00;
      count_0        <= '0;
      count_1        <= '0;
      tag_0          <= '0;
      tag_1          <= '0;
      frame_counter  <= '0;
    end else begin
      if (cfg_write) capture_enable <= pwdata[0];
      grab_buffer    <= grab_buffer_next;
      write_position <= write_position_next;
      finished_flags <= finished_flags_next;
      lock_flags     <= lock_flags_next;
      count_0        <= count_0_next;
      count_1        <= count_1_next;
      tag_0          <= tag_0_next;
      tag_1          <= tag_1_next;
      frame_counter  <= frame_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store[store_waddr] <= segment_word;
  end

  always_ff @(posedge clk) begin
    if (store_re) store_rdata <= store[store_raddr];
  end

  // middle stage: waits for the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_status <= st_c;
      s1_index  <= idx_c;
      s1_count  <= cnt_out_wide[11:0];
      s1_tag    <= tag_c;
      s1_read   <= read_ok_c;
      s1_new    <= |finished_flags_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status        <= s1_status;
      buffer_index  <= s1_index;
      segment_count <= s1_count;
      frame_tag     <= s1_tag;
      read_word     <= s1_read ? store_rdata : 32'b0;
      new_data      <= s1_new;
    end
  end

endmodule

// ===== rtl/core/spc_checker.sv =====
// Port-level checks for the segment ping-pong capture core, with its bind.
`timescale 1ns / 1ps

module spc_checker
  import spc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic        buffer_index,
  input logic [11:0] segment_count,
  input logic [31:0] frame_tag,
  input logic [31:0] read_word
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(read_word))
    else $error("stalled result word changed");

  // every accepted word is followed by a valid result word
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |-> ##2 result_valid)
    else $error("result missing after accepted word");

  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= ST_DROPPED)
    else $error("status code out of range");

  // grant and read fields are zero unless the operation succeeded
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |->
      !buffer_index && segment_count == 12'd0 && frame_tag == 32'd0 && read_word == 32'd0)
    else $error("payload set on failed operation");

endmodule

bind segment_ping_pong_capture_core spc_checker u_spc_checker (.*);

// ===== test/segment_ping_pong_capture_checker.sv =====
// Checker for the segment ping-pong capture core: predicts each result and compares.
`timescale 1ns / 1ps

module segment_ping_pong_capture_checker
  import spc_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [2:0]  action,
  input  logic [31:0] segment_word,
  input  logic [1:0]  buffer_sel,
  input  logic [10:0] entry_addr,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [2:0]  status,
  input  logic        buffer_index,
  input  logic [11:0] segment_count,
  input  logic [31:0] frame_tag,
  input  logic [31:0] read_word,
  input  logic        new_data,
  output int          fail_count,
  output int          outstanding
);

  localparam logic [2:0] CAPTURE_ENABLE_ADDR = {REG_CAPTURE_ENABLE, 2'b00};

  typedef struct packed {
    status_t     status;
    logic        buffer_index;
    logic [11:0] segment_count;
    logic [31:0] frame_tag;
    logic [31:0] read_word;
    logic        new_data;
  } capture_result_t;

  // shadow of the capture state
  bit          capture_on;
  bit          grab_sel;
  bit [11:0]   wr_pos;
  bit [1:0]    done_flags;
  bit [1:0]    held_flags;
  bit [11:0]   buf_count [2];
  bit [31:0]   buf_tag [2];
  bit [31:0]   frame_no;
  bit [31:0]   word_store [2*BUFFER_DEPTH];

  capture_result_t pending_results[$];
  int mismatches = 0;

  task automatic apply_capture_word(input logic [2:0] act, input logic [31:0] word,
                                    input logic [1:0] sel, input logic [10:0] addr,
                                    output capture_result_t r);
    bit g;
    bit b;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_WORD: begin
        if (!capture_on) begin
          r.status = ST_DISABLED;
        end else if (wr_pos >= BUFFER_DEPTH) begin
          wr_pos   = 12'(BUFFER_DEPTH);
          r.status = ST_DROPPED;
        end else begin
          word_store[int'(grab_sel) * BUFFER_DEPTH + int'(wr_pos)] = word;
          wr_pos = wr_pos + 12'd1;
        end
      end
      ACT_FRAME_END: begin
        if (!capture_on) begin
          r.status = ST_DISABLED;
        end else begin
          g = grab_sel;
          buf_count[g]  = wr_pos;
          done_flags[g] = 1'b1;
          buf_tag[g]    = frame_no;
          // move to the other buffer unless it is held
          if (g == 1'b1 && !held_flags[0]) g = 1'b0;
          else if (g == 1'b0 && !held_flags[1]) g = 1'b1;
          else if (!held_flags[0]) g = 1'b0;
          else if (!held_flags[1]) g = 1'b1;
          grab_sel      = g;
          done_flags[g] = 1'b0;
          wr_pos        = '0;
        end
        frame_no = frame_no + 32'd1;
      end
      ACT_LOCK: begin
        if (!capture_on) begin
          r.status = ST_DISABLED;
        end else if (done_flags == 2'b00) begin
          r.status = ST_NONE;
        end else begin
          b = done_flags[0] ? 1'b0 : 1'b1;
          held_flags[b]   = 1'b1;
          r.buffer_index  = b;
          r.segment_count = buf_count[b];
          r.frame_tag     = buf_tag[b];
        end
      end
      ACT_UNLOCK: begin
        if (sel >= 2'd2) begin
          r.status = ST_BAD_INDEX;
        end else begin
          done_flags[sel[0]] = 1'b0;
          held_flags[sel[0]] = 1'b0;
        end
      end
      ACT_READ: begin
        if (sel >= 2'd2 || 12'(addr) >= buf_count[sel[0]]) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.read_word = word_store[int'(sel[0]) * BUFFER_DEPTH + int'(addr)];
        end
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.new_data = |done_flags;
  endtask

  always @(posedge clk) begin : monitor
    capture_result_t want;
    if (rst) begin
      capture_on   = 1'b0;
      grab_sel     = 1'b0;
      wr_pos       = '0;
      done_flags   = '0;
      held_flags   = '0;
      buf_count[0] = '0;
      buf_count[1] = '0;
      buf_tag[0]   = '0;
      buf_tag[1]   = '0;
      frame_no     = '0;
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAPTURE_ENABLE_ADDR) begin
        capture_on = pwdata[0];
        // enabling re-arms both buffers
        if (capture_on) begin
          done_flags = '0;
          held_flags = '0;
        end
      end
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status expected %0d got %0d", want.status, status);
            mismatches++;
          end
          if (buffer_index !== want.buffer_index) begin
            $error("buffer_index expected %0d got %0d", want.buffer_index, buffer_index);
            mismatches++;
          end
          if (segment_count !== want.segment_count) begin
            $error("segment_count expected %0d got %0d", want.segment_count, segment_count);
            mismatches++;
          end
          if (frame_tag !== want.frame_tag) begin
            $error("frame_tag expected %h got %h", want.frame_tag, frame_tag);
            mismatches++;
          end
          if (read_word !== want.read_word) begin
            $error("read_word expected %h got %h", want.read_word, read_word);
            mismatches++;
          end
          if (new_data !== want.new_data) begin
            $error("new_data expected %0d got %0d", want.new_data, new_data);
            mismatches++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        apply_capture_word(action, segment_word, buffer_sel, entry_addr, want);
        pending_results.push_back(want);
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== test/tb_segment_ping_pong_capture_core.sv =====
// Testbench top for the segment ping-pong capture core: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_segment_ping_pong_capture_core
  import spc_pkg::*;
();

  localparam logic [2:0] CAPTURE_ENABLE_ADDR = {REG_CAPTURE_ENABLE, 2'b00};
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [2:0]  action = '0;
  logic [31:0] segment_word = '0;
  logic [1:0]  buffer_sel = '0;
  logic [10:0] entry_addr = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  status;
  logic        buffer_index;
  logic [11:0] segment_count;
  logic [31:0] frame_tag;
  logic [31:0] read_word;
  logic        new_data;

  int fail_count;
  int outstanding;
  int send_pct = 0;
  int recv_pct = 0;
  int words_sent = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  segment_ping_pong_capture_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH_DEFAULT)
  ) i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall), .action(action),
    .segment_word(segment_word), .buffer_sel(buffer_sel), .entry_addr(entry_addr),
    .result_valid(result_valid), .result_stall(result_stall), .status(status),
    .buffer_index(buffer_index), .segment_count(segment_count), .frame_tag(frame_tag),
    .read_word(read_word), .new_data(new_data)
  );

  segment_ping_pong_capture_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH_DEFAULT)
  ) i_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall), .action(action),
    .segment_word(segment_word), .buffer_sel(buffer_sel), .entry_addr(entry_addr),
    .result_valid(result_valid), .result_stall(result_stall), .status(status),
    .buffer_index(buffer_index), .segment_count(segment_count), .frame_tag(frame_tag),
    .read_word(read_word), .new_data(new_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // result side: random stall plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_seen    <= 1'b0;
      hold_left    <= 0;
    end else begin
      hold_seen <= hold_req;
      if (hold_req && !hold_seen) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      result_stall <= (hold_req && !hold_seen) || (hold_left > 1) ||
                      ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_segment_ping_pong_capture_core: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [31:0] word,
                           input logic [1:0] sel, input logic [10:0] addr);
    while ($urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    action       <= act;
    segment_word <= word;
    buffer_sel   <= sel;
    entry_addr   <= addr;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capture_enable(input bit en);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPTURE_ENABLE_ADDR;
    pwdata  <= {31'd0, en};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_noise();
    send_item(3'($urandom_range(7)), $urandom, 2'($urandom_range(3)),
              11'($urandom_range(2047)));
  endtask

  // words, frame end, then mostly lock / read back / unlock
  task automatic random_frame();
    int n;
    int k;
    n = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
    for (k = 0; k < n; k++) begin
      send_item(ACT_WORD, $urandom, 2'($urandom_range(3)), 11'($urandom_range(2047)));
    end
    send_item(ACT_FRAME_END, $urandom, 2'($urandom_range(3)), 11'($urandom_range(2047)));
    if ($urandom_range(3) != 0) begin
      send_item(ACT_LOCK, $urandom, 2'($urandom_range(3)), 11'($urandom_range(2047)));
    end
    repeat ($urandom_range(4)) begin
      send_item(ACT_READ, $urandom, 2'($urandom_range(1)), 11'($urandom_range(n)));
    end
    if ($urandom_range(2) != 0) begin
      send_item(ACT_UNLOCK, $urandom, 2'($urandom_range(1)), 11'($urandom_range(2047)));
    end
  endtask

  task automatic random_phase(input int s_pct, input int r_pct, input int count);
    int stop_at;
    send_pct <= s_pct;
    recv_pct <= r_pct;
    @(posedge clk);
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(4) != 0) begin
        random_frame();
      end else begin
        repeat (1 + $urandom_range(4)) send_noise();
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // capture disabled out of reset
    send_item(ACT_WORD, 32'h0000_0000, 2'd0, 11'd0);
    send_item(ACT_WORD, 32'hFFFF_FFFF, 2'd3, 11'd2047);
    send_item(ACT_FRAME_END, 32'd0, 2'd0, 11'd0);
    send_item(ACT_LOCK, 32'd0, 2'd0, 11'd0);
    send_item(ACT_UNLOCK, 32'd0, 2'd0, 11'd0);
    send_item(ACT_UNLOCK, 32'd0, 2'd3, 11'd0);
    send_item(ACT_READ, 32'd0, 2'd1, 11'd0);
    send_item(ACT_READ, 32'd0, 2'd2, 11'd2047);
    send_item(3'd5, 32'd0, 2'd0, 11'd0);
    send_item(3'd7, 32'hFFFF_FFFF, 2'd3, 11'd2047);
    drain();

    write_capture_enable(1'b1);
    send_item(ACT_WORD, 32'h0000_0000, 2'd0, 11'd0);
    send_item(ACT_WORD, 32'hFFFF_FFFF, 2'd0, 11'd0);
    send_item(ACT_WORD, 32'h5A5A_A5A5, 2'd0, 11'd0);
    send_item(ACT_FRAME_END, 32'd0, 2'd0, 11'd0);
    send_item(ACT_LOCK, 32'd0, 2'd0, 11'd0);
    send_item(ACT_READ, 32'd0, 2'd0, 11'd2);
    send_item(ACT_READ, 32'd0, 2'd0, 11'd3);
    send_item(ACT_WORD, 32'h1234_5678, 2'd0, 11'd0);
    // buffer 0 held: grab stays on buffer 1
    send_item(ACT_FRAME_END, 32'd0, 2'd0, 11'd0);
    send_item(ACT_LOCK, 32'd0, 2'd0, 11'd0);
    send_item(ACT_UNLOCK, 32'd0, 2'd0, 11'd0);
    send_item(ACT_LOCK, 32'd0, 2'd0, 11'd0);
    send_item(ACT_READ, 32'd0, 2'd1, 11'd0);
    send_item(3'd6, 32'd0, 2'd1, 11'd5);
    drain();

    // fill one buffer past full while the result side holds off
    write_capture_enable(1'b1);
    hold_req <= 1'b1;
    repeat (BUFFER_DEPTH_DEFAULT + 2) send_item(ACT_WORD, $urandom, 2'd0, 11'd0);
    send_item(ACT_FRAME_END, 32'd0, 2'd0, 11'd0);
    send_item(ACT_LOCK, 32'd0, 2'd0, 11'd0);
    send_item(ACT_READ, 32'd0, 2'd0, 11'd2047);
    send_item(ACT_READ, 32'd0, 2'd0, 11'd0);
    send_item(ACT_UNLOCK, 32'd0, 2'd0, 11'd0);
    drain();

    write_capture_enable(1'b1);
    random_phase(0, 0, PHASE_ITEMS);
    write_capture_enable(1'b1);
    random_phase(76, 0, PHASE_ITEMS);
    write_capture_enable(1'b0);
    random_phase(11, 11, 30);
    write_capture_enable(1'b1);
    random_phase(0, 76, PHASE_ITEMS);
    write_capture_enable(1'b1);
    random_phase(11, 11, PHASE_ITEMS);

    if (fail_count == 0) begin
      $display("tb_segment_ping_pong_capture_core: PASS");
    end else begin
      $display("tb_segment_ping_pong_capture_core: FAIL");
    end
    $finish;
  end

endmodule
